// ===== src/plt_pkg.sv =====
package plt_pkg;

	// Input item kinds carried on the slave-side tuser.
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Result status codes carried on the master-side tuser.
	localparam logic [2:0] STAT_EXACT  = 3'd0;
	localparam logic [2:0] STAT_INTERP = 3'd1;
	localparam logic [2:0] STAT_BELOW  = 3'd2;
	localparam logic [2:0] STAT_ABOVE  = 3'd3;
	localparam logic [2:0] STAT_FULL   = 3'd4;
	localparam logic [2:0] STAT_DONE   = 3'd5;

	// Query token that walks the chain of cells, one cell per cycle.
	typedef struct packed {
		logic               vld;   // token present
		logic signed [15:0] q;     // query angle
		logic               hit;   // an exact match was seen
		logic signed [15:0] found; // coefficient of the latest exact match
		logic               done;  // first entry not below the query was seen
		logic               first; // that entry was the first stored entry
		logic               seen;  // at least one stored entry was passed
		logic signed [15:0] a0;    // bracket: entry before the one found
		logic signed [15:0] c0;
		logic signed [15:0] a1;    // bracket: entry found
		logic signed [15:0] c1;
		logic signed [15:0] pa;    // last stored entry passed so far
		logic signed [15:0] pc;
	} plt_tok_t;

endpackage

// ===== src/piecewise_linear_table_lookup.sv =====
// Load and clear items each give one result; kind 3 items are dropped with no result.
// A query that needs no interpolation walks the chain of cells, one cell per cycle.
// An interpolated query follows the cell walk with one multiply, one magnitude step,
// a 34-step serial divide and a final add.
// One item is in work at a time; the next transfer is taken once the result is taken.
// Asynchronous active-low reset empties the table and drops any pending result.
module piecewise_linear_table_lookup import plt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // angle [15:0], coefficient [31:16]
	input  logic [1:0]  s_tuser,  // kind [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // result_coefficient [15:0], entries_held [22:16], zero [23]
	output logic [2:0]  m_tuser   // status [2:0]
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ABS  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]          state_q;
	logic [CW-1:0]       count_q;
	logic                out_v_q;
	logic signed [15:0]  res_q;
	logic [2:0]          stat_q;
	logic [6:0]          held_q;
	plt_tok_t            end_q;
	logic signed [33:0]  prod_q;
	logic signed [16:0]  da_q;
	logic                neg_q;
	logic [33:0]         dvd_q;
	logic [16:0]         rem_q;
	logic [5:0]          cnt_q;

	plt_tok_t            tok [TABLE_DEPTH+1];
	plt_tok_t            tok_first;
	logic                accept;
	logic                wr_en;
	logic                clr;
	logic [CW+6:0]       cnt_ext;
	logic [CW+6:0]       cnt_inc_ext;
	logic [CW-1:0]       count_inc;
	logic                full;
	logic signed [16:0]  dq;
	logic signed [16:0]  dc;
	logic [17:0]         rem_sh;
	logic                rem_ge;
	logic signed [34:0]  step;
	logic signed [35:0]  sum;
	logic signed [15:0]  sat;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE) && !out_v_q;
	assign full      = count_q == CW'(TABLE_DEPTH);
	assign count_inc = count_q + 1'b1;
	assign wr_en     = accept && s_tuser == KIND_LOAD && !full;
	assign clr       = accept && s_tuser == KIND_CLEAR;
	assign cnt_ext     = {7'b0, count_q};
	assign cnt_inc_ext = {7'b0, count_inc};

	// Token entering the first cell.
	always_comb begin
		tok_first     = '0;
		tok_first.vld = accept && s_tuser == KIND_QUERY;
		tok_first.q   = s_tdata[15:0];
	end

	assign tok[0] = tok_first;

	// Chain of breakpoint cells.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		plt_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en),
			.wr_index (count_q),
			.wr_angle (s_tdata[15:0]),
			.wr_coef  (s_tdata[31:16]),
			.clr      (clr),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	// Interpolation arithmetic.
	assign dq     = 17'(end_q.q) - 17'(end_q.a0);
	assign dc     = 17'(end_q.c1) - 17'(end_q.c0);
	assign rem_sh = {rem_q, dvd_q[33]};
	assign rem_ge = rem_sh >= {1'b0, da_q};
	assign step   = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign sum    = 36'(end_q.c0) + 36'(step);

	always_comb begin
		if (sum > 36'sd32767) begin
			sat = 16'sd32767;
		end else if (sum < -36'sd32768) begin
			sat = -16'sd32768;
		end else begin
			sat = sum[15:0];
		end
	end

	// Control, table count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (s_tuser)
							KIND_LOAD: begin
								out_v_q <= 1'b1;
								if (!full) begin
									count_q <= count_inc;
								end
							end
							KIND_QUERY: state_q <= S_SCAN;
							KIND_CLEAR: begin
								count_q <= '0;
								out_v_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (tok[TABLE_DEPTH].vld) begin
						if (tok[TABLE_DEPTH].hit || !tok[TABLE_DEPTH].done ||
								tok[TABLE_DEPTH].first) begin
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: state_q <= S_ABS;
				S_ABS: begin
					cnt_q   <= 6'd33;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q <= '0;
					if (s_tuser == KIND_LOAD) begin
						stat_q <= full ? STAT_FULL : STAT_DONE;
						held_q <= full ? cnt_ext[6:0] : cnt_inc_ext[6:0];
					end else begin
						stat_q <= STAT_DONE;
						held_q <= '0;
					end
				end
			end
			S_SCAN: begin
				end_q  <= tok[TABLE_DEPTH];
				held_q <= cnt_ext[6:0];
				if (tok[TABLE_DEPTH].hit) begin
					res_q  <= tok[TABLE_DEPTH].found;
					stat_q <= STAT_EXACT;
				end else begin
					res_q <= '0;
					if (!tok[TABLE_DEPTH].done) begin
						stat_q <= STAT_ABOVE;
					end else begin
						stat_q <= STAT_BELOW;
					end
				end
			end
			S_MUL: begin
				prod_q <= dq * dc;
				da_q   <= 17'(end_q.a1) - 17'(end_q.a0);
			end
			S_ABS: begin
				neg_q <= prod_q[33];
				dvd_q <= prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_ge ? 17'(rem_sh - {1'b0, da_q}) : rem_sh[16:0];
				dvd_q <= {dvd_q[32:0], rem_ge};
			end
			S_FIN: begin
				res_q  <= sat;
				stat_q <= STAT_INTERP;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, held_q, res_q};
	assign m_tuser  = stat_q;

endmodule

// ===== src/plt_cell.sv =====
module plt_cell import plt_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CW-1:0]      wr_index,
	input  logic signed [15:0] wr_angle,
	input  logic signed [15:0] wr_coef,
	input  logic               clr,
	input  plt_tok_t           tok_in,
	output plt_tok_t           tok_out
);

	logic               valid_q;
	logic signed [15:0] angle_q;
	logic signed [15:0] coef_q;
	plt_tok_t           tok_d;
	plt_tok_t           tok_q;

	// Valid bit of the stored breakpoint.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (wr_en && wr_index == CW'(IDX)) begin
			valid_q <= 1'b1;
		end
	end

	// Stored breakpoint pair.
	always_ff @(posedge clk) begin
		if (wr_en && wr_index == CW'(IDX)) begin
			angle_q <= wr_angle;
			coef_q  <= wr_coef;
		end
	end

	// Update the passing token with this cell's entry.
	always_comb begin
		tok_d = tok_in;
		if (tok_in.vld && valid_q) begin
			if (angle_q == tok_in.q) begin
				tok_d.hit   = 1'b1;
				tok_d.found = coef_q;
			end
			if (!tok_in.done && !(angle_q < tok_in.q)) begin
				tok_d.done  = 1'b1;
				tok_d.first = !tok_in.seen;
				tok_d.a0    = tok_in.pa;
				tok_d.c0    = tok_in.pc;
				tok_d.a1    = angle_q;
				tok_d.c1    = coef_q;
			end
			tok_d.seen = 1'b1;
			tok_d.pa   = angle_q;
			tok_d.pc   = coef_q;
		end
	end

	// Hand the token to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule
